>>> design/i2cm_pkg.sv
// Shared types and constants of the I2C master byte engine.
package i2cm_pkg;

   localparam int DATA_BITS  = 8;
   localparam int DELAY_W    = 16;
   localparam int BITCNT_W   = 4;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   // Command codes as they arrive in tuser; CMD_NONE also marks an idle engine.
   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_START = 3'd1,
      CMD_STOP  = 3'd2,
      CMD_WRITE = 3'd3,
      CMD_READ  = 3'd4
   } cmd_type;

   // Sequencer phases. Start and stop walk through the first two or three.
   typedef enum logic [2:0] {
      PH_BIT_SDA    = 3'd0,
      PH_BIT_SCL_HI = 3'd1,
      PH_BIT_SCL_LO = 3'd2,
      PH_ACK_HI     = 3'd3,
      PH_ACK_LO     = 3'd4,
      PH_TAIL       = 3'd5
   } phase_type;

   // One classified item handed from the front to the back.
   typedef struct packed {
      cmd_type              kind;
      logic [DATA_BITS-1:0] tx_byte;
      logic                 send_ack;
      logic                 sda_in;
   } item_type;

   // Response tdata bit positions.
   localparam int RSP_SCL_BIT  = 0;
   localparam int RSP_SDA_BIT  = 1;
   localparam int RSP_BUSY_BIT = 2;
   localparam int RSP_RX_LSB   = 3;
   localparam int RSP_ACK_BIT  = RSP_RX_LSB + DATA_BITS;
   localparam int RSP_REJ_BIT  = RSP_ACK_BIT + 1;

endpackage

>>> design/i2cm_front.sv
// Front end: unpacks a request transfer and classifies its command code.
module i2cm_front (
   input  logic [2:0]                      req_tuser,
   input  logic [i2cm_pkg::REQ_DATA_W-1:0] req_tdata,
   output i2cm_pkg::item_type              item
);
   import i2cm_pkg::*;

   always_comb begin
      case (req_tuser)
         CMD_START: item.kind = CMD_START;
         CMD_STOP:  item.kind = CMD_STOP;
         CMD_WRITE: item.kind = CMD_WRITE;
         CMD_READ:  item.kind = CMD_READ;
         default:   item.kind = CMD_NONE;   // tick and unused codes
      endcase
      item.tx_byte  = req_tdata[DATA_BITS-1:0];
      item.send_ack = req_tdata[DATA_BITS];
      item.sda_in   = req_tdata[DATA_BITS+1];
   end

endmodule

>>> design/i2cm_queue.sv
// Two-entry queue between the classifier and the sequencer.
module i2cm_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  i2cm_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output i2cm_pkg::item_type head
);
   import i2cm_pkg::*;

   item_type   mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> design/i2cm_seq.sv
// Back end: bus phase sequencer, delay counter and registered response.
module i2cm_seq (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [i2cm_pkg::DELAY_W-1:0]    csr_wdata,
   input  logic                            item_valid,
   input  i2cm_pkg::item_type              item,
   output logic                            item_pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [i2cm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast
);
   import i2cm_pkg::*;

   logic [DELAY_W-1:0]   ticks_ff;
   cmd_type              active_ff, active_in;
   phase_type            phase_ff, phase_in;
   logic [BITCNT_W-1:0]  bits_ff, bits_in;
   logic [DATA_BITS-1:0] shift_ff, shift_in;
   logic [DELAY_W-1:0]   delay_ff, delay_in;
   logic                 ack_ff, ack_in;
   logic                 scl_ff, scl_in;
   logic                 sda_ff, sda_in;
   logic                 last_ack_ff, last_ack_in;
   logic [DATA_BITS-1:0] rx_ff, rx_in;
   logic                 done_in, rej_in;
   logic                 out_valid_ff;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;
   logic                 out_last_ff;

   assign item_pop   = item_valid && (!out_valid_ff || rsp_tready);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   always_comb begin
      logic               enter;
      logic [DELAY_W-1:0] dec;
      logic [BITCNT_W-1:0] bits_inc;
      enter       = 1'b0;
      active_in   = active_ff;
      phase_in    = phase_ff;
      bits_in     = bits_ff;
      shift_in    = shift_ff;
      delay_in    = delay_ff;
      ack_in      = ack_ff;
      scl_in      = scl_ff;
      sda_in      = sda_ff;
      last_ack_in = last_ack_ff;
      rx_in       = rx_ff;
      done_in     = 1'b0;
      rej_in      = 1'b0;
      dec         = (delay_ff != '0) ? delay_ff - 1'b1 : delay_ff;
      bits_inc    = bits_ff + 1'b1;

      if (active_ff == CMD_NONE) begin
         if (item.kind != CMD_NONE) begin
            active_in = item.kind;
            bits_in   = '0;
            enter     = 1'b1;
            phase_in  = PH_BIT_SDA;
            if (item.kind == CMD_WRITE) begin
               shift_in = item.tx_byte;
            end else if (item.kind == CMD_READ) begin
               shift_in = '0;
               ack_in   = item.send_ack;
               phase_in = PH_ACK_HI;
            end
         end
      end else begin
         rej_in   = (item.kind != CMD_NONE);
         delay_in = dec;
         if (dec == '0) begin
            enter = 1'b1;
            case (active_ff)
               CMD_START: begin
                  if (phase_ff == PH_BIT_SDA) phase_in = PH_BIT_SCL_HI;
                  else if (phase_ff == PH_BIT_SCL_HI) phase_in = PH_BIT_SCL_LO;
                  else done_in = 1'b1;
               end
               CMD_STOP: begin
                  if (phase_ff == PH_BIT_SDA) phase_in = PH_BIT_SCL_HI;
                  else done_in = 1'b1;
               end
               CMD_WRITE: begin
                  case (phase_ff)
                     PH_BIT_SDA:    phase_in = PH_BIT_SCL_HI;
                     PH_BIT_SCL_HI: phase_in = PH_BIT_SCL_LO;
                     PH_BIT_SCL_LO: begin
                        shift_in = {shift_ff[DATA_BITS-2:0], 1'b0};
                        bits_in  = bits_inc;
                        phase_in = (bits_inc < BITCNT_W'(DATA_BITS)) ? PH_BIT_SDA
                                                                      : PH_ACK_HI;
                     end
                     PH_ACK_HI: begin
                        last_ack_in = item.sda_in;
                        phase_in    = PH_ACK_LO;
                     end
                     default: done_in = 1'b1;
                  endcase
               end
               default: begin   // read
                  case (phase_ff)
                     PH_ACK_HI: begin
                        shift_in = {shift_ff[DATA_BITS-2:0], item.sda_in};
                        phase_in = PH_ACK_LO;
                     end
                     PH_ACK_LO: begin
                        bits_in  = bits_inc;
                        phase_in = (bits_inc < BITCNT_W'(DATA_BITS)) ? PH_ACK_HI
                                                                      : PH_BIT_SDA;
                     end
                     PH_BIT_SDA:    phase_in = PH_BIT_SCL_HI;
                     PH_BIT_SCL_HI: phase_in = PH_BIT_SCL_LO;
                     PH_BIT_SCL_LO: phase_in = PH_TAIL;
                     default: begin
                        rx_in   = shift_ff;
                        done_in = 1'b1;
                     end
                  endcase
               end
            endcase
            if (done_in) begin
               enter     = 1'b0;
               active_in = CMD_NONE;
               phase_in  = PH_BIT_SDA;
               bits_in   = '0;
               delay_in  = '0;
            end
         end
      end

      // Line drives of the phase just entered.
      if (enter) begin
         if (active_in == CMD_START) begin
            if (phase_in == PH_BIT_SDA) begin
               scl_in = 1'b0;
               sda_in = 1'b0;
            end else if (phase_in == PH_BIT_SCL_HI) sda_in = 1'b1;
            else scl_in = 1'b1;
         end else if (active_in == CMD_STOP) begin
            if (phase_in == PH_BIT_SDA) scl_in = 1'b0;
            else sda_in = 1'b0;
         end else begin
            case (phase_in)
               PH_BIT_SDA: begin
                  if (active_in == CMD_WRITE) sda_in = ~shift_in[DATA_BITS-1];
                  else sda_in = ack_in;
               end
               PH_BIT_SCL_HI: scl_in = 1'b0;
               PH_BIT_SCL_LO: scl_in = 1'b1;
               PH_ACK_HI: begin
                  sda_in = 1'b0;
                  scl_in = 1'b0;
               end
               PH_ACK_LO: scl_in = 1'b1;
               default: ;
            endcase
         end
         delay_in = (ticks_ff == '0) ? DELAY_W'(1) : ticks_ff;
      end

      out_data_in = '0;
      out_data_in[RSP_SCL_BIT]  = scl_in;
      out_data_in[RSP_SDA_BIT]  = sda_in;
      out_data_in[RSP_BUSY_BIT] = (active_in != CMD_NONE);
      out_data_in[RSP_RX_LSB +: DATA_BITS] = rx_in;
      out_data_in[RSP_ACK_BIT]  = last_ack_in;
      out_data_in[RSP_REJ_BIT]  = rej_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff     <= DELAY_W'(1);
         active_ff    <= CMD_NONE;
         phase_ff     <= PH_BIT_SDA;
         bits_ff      <= '0;
         shift_ff     <= '0;
         delay_ff     <= '0;
         ack_ff       <= 1'b0;
         scl_ff       <= 1'b0;
         sda_ff       <= 1'b0;
         last_ack_ff  <= 1'b0;
         rx_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            ticks_ff <= csr_wdata;
         end
         if (item_pop) begin
            active_ff   <= active_in;
            phase_ff    <= phase_in;
            bits_ff     <= bits_in;
            shift_ff    <= shift_in;
            delay_ff    <= delay_in;
            ack_ff      <= ack_in;
            scl_ff      <= scl_in;
            sda_ff      <= sda_in;
            last_ack_ff <= last_ack_in;
            rx_ff       <= rx_in;
         end
         if (item_pop) out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         out_data_ff <= out_data_in;
         out_last_ff <= done_in;
      end
   end

endmodule

>>> design/i2c_master_byte_engine_core.sv
// Top level of the I2C master byte engine.
//
// Open-drain I2C master sequencer. Every request transfer is one tick of time
// and may carry a command (start, stop, write byte, read byte); each request
// yields exactly one response transfer with the SCL/SDA drive levels, busy,
// done (tlast), last received byte, last write acknowledge and a rejected
// flag for commands that arrived while a sequence was running. A bus phase
// lasts csr ticks_per_delay requests (0 acts as 1). Throughput is one request
// per clock while the queue has room: the classifier front end feeds a
// two-entry queue, and the sequencer back end retires one queued item per
// cycle into a response register whenever that register is empty or being
// drained. Each request passes the queue, then the response register. The
// delay register is meant to be written only while the engine is idle.
module i2c_master_byte_engine_core (
   input  logic        clock,
   input  logic        reset,
   // configuration: ticks_per_delay
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] tx_byte, [8] send_ack, [9] sda_in, rest 0
   input  logic [2:0]  req_tuser,   // [2:0] cmd
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [0] scl_low, [1] sda_low, [2] busy_res,
                                    // [10:3] rx_byte, [11] slave_ack, [12] rejected
   output logic        rsp_tlast    // done_res
);
   import i2cm_pkg::*;

   item_type front_item;
   item_type head_item;
   logic     q_full;
   logic     q_not_empty;
   logic     q_pop;
   logic     q_push;

   // A request is taken whenever the queue has room.
   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   i2cm_front u_front (
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .item      (front_item)
   );

   i2cm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (head_item)
   );

   // Sequencer: counts items down through the bus phases, response register on its output.
   i2cm_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .item_valid (q_not_empty),
      .item       (head_item),
      .item_pop   (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> design/i2cm_checker.sv
// Port-level checks of the I2C master byte engine, bound to the top level.
module i2cm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);
   import i2cm_pkg::*;

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   // The transfer that finishes a sequence reports the engine idle.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> !rsp_tdata[RSP_BUSY_BIT])
      else $error("done reported while still busy");

   // Nothing is presented right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // Queue is empty out of reset, so the first request can always go in.
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("request not ready after reset");

endmodule

bind i2c_master_byte_engine_core i2cm_checker u_i2cm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

>>> sim/i2c_line_checker.sv
`timescale 1ns / 1ps
// Line-level predictor and response checker for the I2C master byte engine.
module i2c_line_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [i2cm_pkg::DELAY_W-1:0]    csr_wdata,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [i2cm_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [2:0]                      req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [i2cm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            rsp_tlast,
   output int                              pending,
   output int                              mismatches
);
   import i2cm_pkg::*;

   typedef struct packed {
      logic                 scl_low;
      logic                 sda_low;
      logic                 busy;
      logic                 done;
      logic [DATA_BITS-1:0] rx_byte;
      logic                 slave_ack;
      logic                 rejected;
   } line_state_type;

   line_state_type line_state_q[$];

   // engine copy
   logic [DELAY_W-1:0]   delay_cfg;
   logic [2:0]           cur_cmd;
   phase_type            cur_phase;
   logic [BITCNT_W-1:0]  bits_done;
   logic [DATA_BITS-1:0] shifter;
   logic [DELAY_W-1:0]   ticks_left;
   logic                 ack_sel;
   logic                 scl_drv;
   logic                 sda_drv;
   logic                 wr_ack;
   logic [DATA_BITS-1:0] rx_hold;

   int err_tally = 0;

   initial begin
      pending    = 0;
      mismatches = 0;
   end

   task report_mismatch(input string what, input int got, input int want);
      err_tally++;
      $display("%0t checker: %s got %0d want %0d", $time, what, got, want);
   endtask

   task clear_engine();
      delay_cfg  = 16'd1;
      cur_cmd    = CMD_NONE;
      cur_phase  = PH_BIT_SDA;
      bits_done  = '0;
      shifter    = '0;
      ticks_left = '0;
      ack_sel    = 1'b0;
      scl_drv    = 1'b0;
      sda_drv    = 1'b0;
      wr_ack     = 1'b0;
      rx_hold    = '0;
   endtask

   // drives of the phase just entered, then reload the phase timer
   task enter_phase();
      if (cur_cmd == CMD_START) begin
         if (cur_phase == PH_BIT_SDA) begin
            scl_drv = 1'b0;
            sda_drv = 1'b0;
         end else if (cur_phase == PH_BIT_SCL_HI) begin
            sda_drv = 1'b1;
         end else begin
            scl_drv = 1'b1;
         end
      end else if (cur_cmd == CMD_STOP) begin
         if (cur_phase == PH_BIT_SDA) scl_drv = 1'b0;
         else sda_drv = 1'b0;
      end else begin
         case (cur_phase)
            PH_BIT_SDA: begin
               // write: data bit; read: low for ACK, released for NACK
               if (cur_cmd == CMD_WRITE) sda_drv = ~shifter[DATA_BITS-1];
               else sda_drv = ack_sel;
            end
            PH_BIT_SCL_HI: scl_drv = 1'b0;
            PH_BIT_SCL_LO: scl_drv = 1'b1;
            PH_ACK_HI: begin
               sda_drv = 1'b0;
               scl_drv = 1'b0;
            end
            PH_ACK_LO: scl_drv = 1'b1;
            default: ;
         endcase
      end
      ticks_left = (delay_cfg == '0) ? 16'd1 : delay_cfg;
   endtask

   task leave_phase(input logic sda, output logic seq_end);
      seq_end = 1'b0;
      if (cur_cmd == CMD_START) begin
         if (cur_phase >= PH_BIT_SCL_LO) seq_end = 1'b1;
         else if (cur_phase == PH_BIT_SDA) cur_phase = PH_BIT_SCL_HI;
         else cur_phase = PH_BIT_SCL_LO;
      end else if (cur_cmd == CMD_STOP) begin
         if (cur_phase >= PH_BIT_SCL_HI) seq_end = 1'b1;
         else cur_phase = PH_BIT_SCL_HI;
      end else if (cur_cmd == CMD_WRITE) begin
         case (cur_phase)
            PH_BIT_SDA:    cur_phase = PH_BIT_SCL_HI;
            PH_BIT_SCL_HI: cur_phase = PH_BIT_SCL_LO;
            PH_BIT_SCL_LO: begin
               shifter   = shifter << 1;
               bits_done = bits_done + 1'b1;
               if (bits_done < DATA_BITS) cur_phase = PH_BIT_SDA;
               else cur_phase = PH_ACK_HI;
            end
            PH_ACK_HI: begin
               wr_ack    = sda;
               cur_phase = PH_ACK_LO;
            end
            default: seq_end = 1'b1;
         endcase
      end else begin
         case (cur_phase)
            PH_ACK_HI: begin
               shifter   = {shifter[DATA_BITS-2:0], sda};
               cur_phase = PH_ACK_LO;
            end
            PH_ACK_LO: begin
               bits_done = bits_done + 1'b1;
               if (bits_done < DATA_BITS) cur_phase = PH_ACK_HI;
               else cur_phase = PH_BIT_SDA;
            end
            PH_BIT_SDA:    cur_phase = PH_BIT_SCL_HI;
            PH_BIT_SCL_HI: cur_phase = PH_BIT_SCL_LO;
            PH_BIT_SCL_LO: cur_phase = PH_TAIL;
            default: begin
               rx_hold = shifter;
               seq_end = 1'b1;
            end
         endcase
      end
      if (!seq_end) enter_phase();
   endtask

   task advance_engine(input logic [2:0] cmd, input logic [DATA_BITS-1:0] tx,
                       input logic sack, input logic sda, output line_state_type res);
      logic is_cmd;
      logic seq_end;
      is_cmd       = (cmd >= CMD_START) && (cmd <= CMD_READ);
      res.rejected = 1'b0;
      res.done     = 1'b0;
      if (cur_cmd == CMD_NONE) begin
         if (is_cmd) begin
            cur_cmd   = cmd;
            bits_done = '0;
            if (cmd == CMD_WRITE) begin
               shifter   = tx;
               cur_phase = PH_BIT_SDA;
            end else if (cmd == CMD_READ) begin
               shifter   = '0;
               ack_sel   = sack;
               cur_phase = PH_ACK_HI;
            end else begin
               cur_phase = PH_BIT_SDA;
            end
            enter_phase();
         end
      end else begin
         // busy: a command is dropped but still counts as a tick
         res.rejected = is_cmd;
         if (ticks_left != '0) ticks_left = ticks_left - 1'b1;
         if (ticks_left == '0) begin
            leave_phase(sda, seq_end);
            if (seq_end) begin
               cur_cmd    = CMD_NONE;
               cur_phase  = PH_BIT_SDA;
               bits_done  = '0;
               ticks_left = '0;
               res.done   = 1'b1;
            end
         end
      end
      res.scl_low   = scl_drv;
      res.sda_low   = sda_drv;
      res.busy      = (cur_cmd != CMD_NONE);
      res.rx_byte   = rx_hold;
      res.slave_ack = wr_ack;
   endtask

   always @(posedge clock) begin : watch
      line_state_type want;
      line_state_type seen;
      if (reset) begin
         clear_engine();
         line_state_q.delete();
      end else begin
         if (csr_we) delay_cfg = csr_wdata;
         if (rsp_tvalid && rsp_tready) begin
            seen.scl_low   = rsp_tdata[RSP_SCL_BIT];
            seen.sda_low   = rsp_tdata[RSP_SDA_BIT];
            seen.busy      = rsp_tdata[RSP_BUSY_BIT];
            seen.done      = rsp_tlast;
            seen.rx_byte   = rsp_tdata[RSP_RX_LSB +: DATA_BITS];
            seen.slave_ack = rsp_tdata[RSP_ACK_BIT];
            seen.rejected  = rsp_tdata[RSP_REJ_BIT];
            if (line_state_q.size() == 0) begin
               report_mismatch("response with nothing pending", 0, 0);
            end else begin
               want = line_state_q.pop_front();
               if (seen.scl_low !== want.scl_low)
                  report_mismatch("scl_low", seen.scl_low, want.scl_low);
               if (seen.sda_low !== want.sda_low)
                  report_mismatch("sda_low", seen.sda_low, want.sda_low);
               if (seen.busy !== want.busy)
                  report_mismatch("busy", seen.busy, want.busy);
               if (seen.done !== want.done)
                  report_mismatch("done", seen.done, want.done);
               if (seen.rx_byte !== want.rx_byte)
                  report_mismatch("rx_byte", seen.rx_byte, want.rx_byte);
               if (seen.slave_ack !== want.slave_ack)
                  report_mismatch("slave_ack", seen.slave_ack, want.slave_ack);
               if (seen.rejected !== want.rejected)
                  report_mismatch("rejected", seen.rejected, want.rejected);
            end
         end
         if (req_tvalid && req_tready) begin
            advance_engine(req_tuser, req_tdata[DATA_BITS-1:0], req_tdata[DATA_BITS],
                           req_tdata[DATA_BITS+1], want);
            line_state_q.push_back(want);
         end
      end
      pending    <= line_state_q.size();
      mismatches <= err_tally;
   end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Top of the I2C master byte engine testbench: clock, reset, stimulus and verdict.
module testbench;
   import i2cm_pkg::*;

   // codes 5..7 are not commands; the engine treats them as ticks
   localparam logic [2:0] CMD_UNDEF_HI = 3'd7;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [DELAY_W-1:0]    csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [2:0]            req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   int pending;
   int mismatches;

   // percent of cycles each side holds off; changed between phases
   int send_idle_pct = 34;
   int recv_idle_pct = 79;

   int items_sent = 0;

   // ticks_per_delay as currently programmed (reset value 1)
   logic [DELAY_W-1:0] delay_now = 16'd1;

   always #4 clock = ~clock;

   i2c_master_byte_engine_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   i2c_line_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .pending    (pending),
      .mismatches (mismatches)
   );

   // Receiver side: random back-pressure on the response channel.
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Hard stop in case the engine or the handshake hangs.
   initial begin
      #20_000_000;
      $display("testbench: done, errors");
      $finish;
   end

   function automatic int phase_ticks(input logic [2:0] cmd);
      int eff;
      eff = (delay_now == '0) ? 1 : delay_now;
      case (cmd)
         CMD_START: return 3 * eff;
         CMD_STOP:  return 2 * eff;
         CMD_WRITE: return (3 * DATA_BITS + 2) * eff;  // 8 bit cells + ack cell
         CMD_READ:  return (2 * DATA_BITS + 4) * eff;  // 8 samples + ack cell + tail
         default:   return 0;
      endcase
   endfunction

   // negative selects a random SDA level, otherwise the given level
   function automatic logic line_level(input int sel);
      if (sel < 0) return logic'($urandom_range(1));
      return sel[0];
   endfunction

   // One request transfer, with a random hold-off before it. Called right
   // after a rising edge; returns at the edge where the transfer happened.
   task send_item(input logic [2:0] cmd, input logic [DATA_BITS-1:0] tx,
                  input logic sack, input logic sda);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {6'b0, sda, sack, tx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // A command followed by exactly the ticks it needs; noise_pct of those
   // ticks are replaced by arbitrary codes (busy commands get rejected).
   task run_sequence(input logic [2:0] cmd, input logic [DATA_BITS-1:0] tx,
                     input logic sack, input int sda_sel, input int noise_pct);
      int n;
      logic [2:0] code;
      n = phase_ticks(cmd);
      send_item(cmd, tx, sack, line_level(sda_sel));
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < noise_pct) code = 3'($urandom_range(7));
         else code = CMD_NONE;
         send_item(code, 8'($urandom_range(255)), 1'($urandom_range(1)),
                   line_level(sda_sel));
      end
   endtask

   // Mostly well-formed command sequences with random bytes and line levels,
   // some bursts of arbitrary items that can start sequences of their own, and a few
   // idle ticks in between.
   task run_random(input int count);
      int stop_at;
      logic [2:0] code;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         if ($urandom_range(99) < 85) begin
            code = 3'($urandom_range(CMD_READ, CMD_START));
            run_sequence(code, 8'($urandom_range(255)), 1'($urandom_range(1)), -1, 4);
         end else begin
            repeat ($urandom_range(6, 1))
               send_item(3'($urandom_range(7)), 8'($urandom_range(255)),
                         1'($urandom_range(1)), 1'($urandom_range(1)));
         end
         repeat ($urandom_range(2))
            send_item(CMD_NONE, 8'($urandom_range(255)), 1'($urandom_range(1)),
                      1'($urandom_range(1)));
      end
   endtask

   // Bring the engine to idle, let every response come back, then program
   // a new delay. Enough ticks to finish the longest sequence go first.
   task program_delay(input logic [DELAY_W-1:0] value);
      repeat (phase_ticks(CMD_WRITE) + 1)
         send_item(CMD_NONE, 8'($urandom_range(255)), 1'($urandom_range(1)),
                   1'($urandom_range(1)));
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      delay_now = value;
   endtask

   initial begin
      int waited;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed, reset delay of one tick.
      send_item(CMD_NONE, 8'h00, 1'b0, 1'b0);            // tick while idle
      send_item(CMD_UNDEF_HI, 8'hFF, 1'b1, 1'b1);        // undefined code while idle
      send_item(CMD_START, 8'h00, 1'b0, 1'b0);
      send_item(CMD_WRITE, 8'hFF, 1'b1, 1'b1);           // busy: rejected, still a tick
      send_item(CMD_UNDEF_HI, 8'h00, 1'b0, 1'b0);        // busy: tick, not rejected
      send_item(CMD_NONE, 8'h00, 1'b0, 1'b0);
      run_sequence(CMD_WRITE, 8'hFF, 1'b0, 1, 0);        // all ones, slave NACKs
      run_sequence(CMD_READ, 8'h00, 1'b1, 0, 0);         // all zeros, master ACKs
      run_sequence(CMD_STOP, 8'h00, 1'b0, 0, 0);

      // Sender idles lightly, receiver heavily.
      program_delay(16'd2);
      run_random(500);

      // Roles swapped.
      send_idle_pct = 79;
      recv_idle_pct = 34;
      program_delay(16'd1);
      run_random(500);
      program_delay(16'd3);
      run_random(300);

      // Full rate on both sides; zero delay behaves as one.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      program_delay(16'd0);
      run_random(300);

      // Longest delay: a stop sequence that stays in its first phase, with
      // arbitrary codes after it (commands among them get rejected).
      program_delay(16'hFFFF);
      send_item(CMD_STOP, 8'($urandom_range(255)), 1'($urandom_range(1)),
                1'($urandom_range(1)));
      repeat (40)
         send_item(3'($urandom_range(7)), 8'($urandom_range(255)),
                   1'($urandom_range(1)), 1'($urandom_range(1)));

      // Drain: all responses back, then a few more cycles of quiet.
      req_tvalid <= 1'b0;
      waited = 0;
      do begin
         @(posedge clock);
         waited++;
      end while (pending != 0 && waited < 20000);
      repeat (8) @(posedge clock);

      if (mismatches == 0 && pending == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
